// ===== rtl/mfd_pkg.sv =====
// shared types, constants and reset values for the motor feedback decoder
package mfd_pkg;

  localparam int SLOT_COUNT   = 7;
  localparam int REG_COUNT    = 7;
  localparam int TRACKED_SLOT = 2;
  localparam int ID_W         = 11;
  localparam int IDX_W        = 3;
  localparam int ANGLE_W      = 16;
  localparam int TURN_W       = 32;
  localparam int TURN_SHIFT   = 13;
  localparam int ID_BASE      = 513;

  localparam logic signed [ANGLE_W-1:0] WRAP_LIMIT = 16'sd5000;

  typedef struct packed {
    logic [ID_W-1:0] frame_id;
    logic [7:0]      byte0;
    logic [7:0]      byte1;
    logic [7:0]      byte2;
    logic [7:0]      byte3;
    logic [7:0]      byte4;
    logic [7:0]      byte5;
    logic [7:0]      byte6;
  } frame_t;

  typedef struct packed {
    logic                      matched;
    logic [IDX_W-1:0]          slot;
    logic [ANGLE_W-1:0]        angle;
    logic signed [15:0]        speed;
    logic signed [15:0]        current;
    logic [7:0]                temperature;
    logic signed [TURN_W-1:0]  turns;
    logic signed [TURN_W-1:0]  travel;
  } result_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] slot;
  } match_t;

  typedef struct packed {
    logic signed [TURN_W-1:0] turns;
    logic signed [TURN_W-1:0] travel;
  } turn_t;

  function automatic logic [ID_W-1:0] id_reset(input int idx);
    id_reset = ID_W'(ID_BASE + idx);
  endfunction

endpackage

// ===== rtl/mfd_frame_if.sv =====
// valid/ready channel carrying one received feedback frame
interface mfd_frame_if;
  logic            valid;
  logic            ready;
  mfd_pkg::frame_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mfd_result_if.sv =====
// valid/ready channel carrying one decoded result
interface mfd_result_if;
  logic             valid;
  logic             ready;
  mfd_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mfd_match.sv =====
// identifier match against the slot registers, lowest slot wins
module mfd_match (
  input  logic [mfd_pkg::ID_W-1:0] ids [mfd_pkg::REG_COUNT],
  input  logic [mfd_pkg::ID_W-1:0] frame_id,
  output mfd_pkg::match_t          match
);

  always_comb begin
    match.hit  = 1'b0;
    match.slot = '0;
    for (int i = mfd_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (ids[i] == frame_id) begin
        match.hit  = 1'b1;
        match.slot = mfd_pkg::IDX_W'(i);
      end
    end
  end

endmodule

// ===== rtl/mfd_turn.sv =====
// turn counter, rearm flag and travel register for the tracked slot
module mfd_turn (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [mfd_pkg::ANGLE_W-1:0]  angle,
  output mfd_pkg::turn_t               turn
);

  logic [mfd_pkg::ANGLE_W-1:0]        prev_r, prev_nxt;
  logic signed [mfd_pkg::TURN_W-1:0]  turns_r, turns_nxt;
  logic signed [mfd_pkg::TURN_W-1:0]  travel_r, travel_nxt;
  logic                               rearm_r, rearm_nxt;
  logic signed [mfd_pkg::ANGLE_W-1:0] delta;
  logic signed [mfd_pkg::TURN_W-1:0]  travel_calc;
  logic                               in_band;

  assign delta   = angle - prev_r;
  assign in_band = (delta >= -mfd_pkg::WRAP_LIMIT) && (delta <= mfd_pkg::WRAP_LIMIT);

  always_comb begin
    turns_nxt = turns_r;
    rearm_nxt = rearm_r;
    if (step) begin
      if (delta < -mfd_pkg::WRAP_LIMIT && rearm_r) begin
        turns_nxt = turns_r + 1;
        rearm_nxt = 1'b0;
      end else if (delta > mfd_pkg::WRAP_LIMIT && rearm_r) begin
        turns_nxt = turns_r - 1;
        rearm_nxt = 1'b0;
      end else if (in_band) begin
        rearm_nxt = 1'b1;
      end
    end
  end

  // angle + (2^13 - 1) * turns
  assign travel_calc = $signed(mfd_pkg::TURN_W'(angle))
                     + (turns_nxt <<< mfd_pkg::TURN_SHIFT) - turns_nxt;
  assign travel_nxt  = step ? travel_calc : travel_r;
  assign prev_nxt    = step ? angle : prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      turns_r  <= '0;
      travel_r <= '0;
      rearm_r  <= 1'b0;
    end else begin
      prev_r   <= prev_nxt;
      turns_r  <= turns_nxt;
      travel_r <= travel_nxt;
      rearm_r  <= rearm_nxt;
    end
  end

  assign turn.turns  = turns_nxt;
  assign turn.travel = travel_nxt;

  a_travel_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    travel_r == $signed(mfd_pkg::TURN_W'(prev_r)) + (turns_r <<< mfd_pkg::TURN_SHIFT) - turns_r)
    else $error("travel out of step with angle and turns");

  a_count_clears_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    step && rearm_r && !in_band |=> !rearm_r)
    else $error("rearm not cleared after a counted turn");

  a_idle_holds_turns: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(turns_r) && $stable(prev_r))
    else $error("turn state moved without a tracked frame");

endmodule

// ===== rtl/motor_feedback_decoder_turn_unwrap.sv =====
// top level: slot registers, input and result registers, turn unwrap
//
//   channel     dir  handshake      payload
//   in_frame    in   valid/ready    frame_id, byte0..byte6
//   out_result  out  valid/ready    matched, slot, angle, speed, current,
//                                   temperature, turns, travel
//   cfg_*       in   cfg_we         cfg_index, cfg_data (no read-back)
//
// one beat per cycle sustained while out_result is ready
// the match and turn update sit between the input register and the result register
// synchronous active-low reset clears valids, turn state and loads slot ids 513..519
// when out_result stalls the result holds and one more frame waits in the input register
module motor_feedback_decoder_turn_unwrap (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mfd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [mfd_pkg::ID_W-1:0]    cfg_data,
  mfd_frame_if.sink                   in_frame,
  mfd_result_if.source                out_result
);

  logic [mfd_pkg::ID_W-1:0] id_r [mfd_pkg::REG_COUNT];
  logic                     s0_valid_r;
  mfd_pkg::frame_t          s0_frame_r;
  logic                     out_valid_r;
  mfd_pkg::result_t         out_data_r, out_data_nxt;
  logic                     advance;
  logic                     step;
  mfd_pkg::match_t          match;
  mfd_pkg::turn_t           turn;
  logic [mfd_pkg::ANGLE_W-1:0] new_angle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mfd_pkg::REG_COUNT; i++) begin
        id_r[i] <= mfd_pkg::id_reset(i);
      end
    end else if (cfg_we && cfg_index < mfd_pkg::IDX_W'(mfd_pkg::REG_COUNT)) begin
      id_r[cfg_index] <= cfg_data;
    end
  end

  assign advance        = s0_valid_r && (!out_valid_r || out_result.ready);
  assign in_frame.ready = !s0_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_frame.ready) begin
        s0_valid_r <= in_frame.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_result.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_frame.ready && in_frame.valid) begin
      s0_frame_r <= in_frame.data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  mfd_match u_match (
    .ids      (id_r),
    .frame_id (s0_frame_r.frame_id),
    .match    (match)
  );

  assign new_angle = {s0_frame_r.byte0, s0_frame_r.byte1};
  assign step = advance && match.hit
             && match.slot == mfd_pkg::IDX_W'(mfd_pkg::TRACKED_SLOT);

  mfd_turn u_turn (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .angle (new_angle),
    .turn  (turn)
  );

  always_comb begin
    out_data_nxt = '0;
    if (match.hit) begin
      out_data_nxt.matched     = 1'b1;
      out_data_nxt.slot        = match.slot;
      out_data_nxt.angle       = new_angle;
      out_data_nxt.speed       = {s0_frame_r.byte2, s0_frame_r.byte3};
      out_data_nxt.current     = {s0_frame_r.byte4, s0_frame_r.byte5};
      out_data_nxt.temperature = s0_frame_r.byte6;
    end
    out_data_nxt.turns  = turn.turns;
    out_data_nxt.travel = turn.travel;
  end

  assign out_result.valid = out_valid_r;
  assign out_result.data  = out_data_r;

  a_miss_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.matched |->
      out_data_r.slot == '0 && out_data_r.angle == '0 && out_data_r.temperature == '0)
    else $error("unmatched beat carries slot data");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.matched |->
      out_data_r.slot < mfd_pkg::IDX_W'(mfd_pkg::SLOT_COUNT))
    else $error("matched slot beyond slot count");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced beat lost before the result register");

endmodule
